[rtl/core/aa55_frame_deframer_macros.svh]
// assertion macros shared by the deframer modules
`ifndef AA55_FRAME_DEFRAMER_MACROS_SVH
`define AA55_FRAME_DEFRAMER_MACROS_SVH

// condition implies consequence in the same cycle
`define AA55_ASSERT_NOW(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("deframer assertion failed");

// condition implies consequence in the next cycle
`define AA55_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

[rtl/core/aa55_pkg.sv]
package aa55_pkg;

    localparam int unsigned SN_LEN  = 8;
    localparam int unsigned MAX_LEN = 248;

    localparam logic [7:0] SOF_BYTE       = 8'hAA;
    localparam logic [7:0] SYNC_BYTE      = 8'h55;
    localparam logic [7:0] MIN_LEN        = 8'd4;
    localparam logic [7:0] LEN_NO_PAYLOAD = 8'd5;
    localparam logic [7:0] SEQ_LEN        = 8'd2;
    localparam logic [7:0] POS_MAX        = 8'd255;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_SYNC = 4'd1,
        PH_TYPE = 4'd2,
        PH_SN   = 4'd3,
        PH_LEN  = 4'd4,
        PH_VER  = 4'd5,
        PH_SEQ  = 4'd6,
        PH_CMD  = 4'd7,
        PH_DATA = 4'd8,
        PH_CHK  = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_SYNC   = 3'd1,
        ERR_LEN_LARGE = 3'd2,
        ERR_LEN_SMALL = 3'd3,
        ERR_CHECKSUM  = 3'd4
    } err_t;

    typedef struct packed {
        logic       in_frame;
        logic       frame_start;
        logic       frame_end;
        logic       frame_good;
        logic [7:0] position;
        err_t       error_kind;
    } res_t;

    typedef struct packed {
        logic [7:0] data;
        logic       source;
        res_t       res;
    } beat_t;

endpackage

[rtl/core/aa55_frame_deframer.sv]
// result beats are registered in main_reg, or in skid_reg while the output stalls
// one byte per cycle while the output is not stalled; parser state updates per byte
// a two-entry output skid keeps s_tready registered; it absorbs one byte on a stall
// reset: synchronous active-low aresetn returns the parser to hunting for 0xAA
// and empties the output stage; no clearing pass is needed
module aa55_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // rx_byte[7:0]
    input  logic        s_tuser,  // source[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // byte_out[7:0], in_frame, frame_start, frame_good,
                                  // position[7:0], error_kind[2:0], zero pad[1:0]
    output logic        m_tuser,  // source_out[0]
    output logic        m_tlast   // frame_end
);

    aa55_pkg::res_t  res;
    aa55_pkg::beat_t in_beat;
    aa55_pkg::beat_t out_beat;
    logic            in_fire;

    assign in_fire = s_tvalid && s_tready;

    aa55_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .res     (res)
    );

    assign in_beat.data   = s_tdata;
    assign in_beat.source = s_tuser;
    assign in_beat.res    = res;

    aa55_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_beat   (in_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat)
    );

    assign m_tdata = {2'b00,
                      out_beat.res.error_kind,
                      out_beat.res.position,
                      out_beat.res.frame_good,
                      out_beat.res.frame_start,
                      out_beat.res.in_frame,
                      out_beat.data};
    assign m_tuser = out_beat.source;
    assign m_tlast = out_beat.res.frame_end;

endmodule

[rtl/core/aa55_parse.sv]
`include "aa55_frame_deframer_macros.svh"

module aa55_parse (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    output aa55_pkg::res_t res
);

    aa55_pkg::phase_t phase_reg, phase_next;
    logic [7:0] field_count_reg, field_count_next;
    logic [7:0] length_low_reg, length_low_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] byte_index_reg, byte_index_next;

    logic       do_open;
    logic       do_frame;
    logic [7:0] cnt_inc;
    logic [7:0] sum_add;
    logic [15:0] length_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= aa55_pkg::PH_HUNT;
            field_count_reg <= 8'd0;
            length_low_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
            byte_index_reg  <= 8'd0;
        end else if (in_fire) begin
            phase_reg       <= phase_next;
            field_count_reg <= field_count_next;
            length_low_reg  <= length_low_next;
            running_sum_reg <= running_sum_next;
            byte_index_reg  <= byte_index_next;
        end
    end

    assign cnt_inc     = 8'(field_count_reg + 8'd1);
    assign sum_add     = 8'(running_sum_reg + in_byte);
    assign length_full = {in_byte, length_low_reg};

    always_comb begin
        phase_next       = phase_reg;
        field_count_next = field_count_reg;
        length_low_next  = length_low_reg;
        running_sum_next = running_sum_reg;
        byte_index_next  = byte_index_reg;
        do_open          = 1'b0;
        do_frame         = 1'b0;
        res              = '0;
        res.error_kind   = aa55_pkg::ERR_NONE;

        unique case (phase_reg)
            aa55_pkg::PH_HUNT: begin
                do_open = (in_byte == aa55_pkg::SOF_BYTE);
            end
            aa55_pkg::PH_SYNC: begin
                if (in_byte == aa55_pkg::SYNC_BYTE) begin
                    do_frame   = 1'b1;
                    phase_next = aa55_pkg::PH_TYPE;
                end else begin
                    res.error_kind = aa55_pkg::ERR_NO_SYNC;
                    if (in_byte == aa55_pkg::SOF_BYTE) begin
                        do_open = 1'b1;
                    end else begin
                        phase_next = aa55_pkg::PH_HUNT;
                    end
                end
            end
            aa55_pkg::PH_TYPE: begin
                do_frame         = 1'b1;
                field_count_next = 8'd0;
                phase_next       = aa55_pkg::PH_SN;
            end
            aa55_pkg::PH_SN: begin
                do_frame = 1'b1;
                if (cnt_inc >= 8'(aa55_pkg::SN_LEN)) begin
                    field_count_next = 8'd0;
                    phase_next       = aa55_pkg::PH_LEN;
                end else begin
                    field_count_next = cnt_inc;
                end
            end
            aa55_pkg::PH_LEN: begin
                do_frame = 1'b1;
                if (field_count_reg == 8'd0) begin
                    length_low_next  = in_byte;
                    field_count_next = 8'd1;
                end else begin
                    field_count_next = 8'd0;
                    if (length_full >= 16'(aa55_pkg::MAX_LEN)) begin
                        res.error_kind = aa55_pkg::ERR_LEN_LARGE;
                        phase_next     = aa55_pkg::PH_HUNT;
                    end else begin
                        running_sum_next = 8'd0;
                        phase_next       = aa55_pkg::PH_VER;
                    end
                end
            end
            aa55_pkg::PH_VER: begin
                do_frame         = 1'b1;
                running_sum_next = sum_add;
                field_count_next = 8'd0;
                phase_next       = aa55_pkg::PH_SEQ;
            end
            aa55_pkg::PH_SEQ: begin
                do_frame         = 1'b1;
                running_sum_next = sum_add;
                if (cnt_inc >= aa55_pkg::SEQ_LEN) begin
                    field_count_next = 8'd0;
                    phase_next       = aa55_pkg::PH_CMD;
                end else begin
                    field_count_next = cnt_inc;
                end
            end
            aa55_pkg::PH_CMD: begin
                running_sum_next = sum_add;
                if (length_low_reg < aa55_pkg::MIN_LEN) begin
                    res.error_kind = aa55_pkg::ERR_LEN_SMALL;
                    if (in_byte == aa55_pkg::SOF_BYTE) begin
                        do_open = 1'b1;
                    end else begin
                        do_frame   = 1'b1;
                        phase_next = aa55_pkg::PH_HUNT;
                    end
                end else begin
                    do_frame = 1'b1;
                    if (length_low_reg <= aa55_pkg::LEN_NO_PAYLOAD) begin
                        phase_next = aa55_pkg::PH_CHK;
                    end else begin
                        field_count_next = 8'(length_low_reg - aa55_pkg::LEN_NO_PAYLOAD);
                        phase_next       = aa55_pkg::PH_DATA;
                    end
                end
            end
            aa55_pkg::PH_DATA: begin
                do_frame         = 1'b1;
                running_sum_next = sum_add;
                field_count_next = 8'(field_count_reg - 8'd1);
                if (field_count_reg == 8'd1) begin
                    phase_next = aa55_pkg::PH_CHK;
                end
            end
            aa55_pkg::PH_CHK: begin
                do_frame      = 1'b1;
                res.frame_end = 1'b1;
                if (in_byte == running_sum_reg) begin
                    res.frame_good = 1'b1;
                end else begin
                    res.error_kind = aa55_pkg::ERR_CHECKSUM;
                end
                phase_next = aa55_pkg::PH_HUNT;
            end
            default: begin
                phase_next = aa55_pkg::PH_HUNT;
            end
        endcase

        if (do_open) begin
            res.in_frame    = 1'b1;
            res.frame_start = 1'b1;
            res.position    = 8'd0;
            byte_index_next = 8'd1;
            phase_next      = aa55_pkg::PH_SYNC;
        end else if (do_frame) begin
            res.in_frame = 1'b1;
            res.position = byte_index_reg;
            if (byte_index_reg != aa55_pkg::POS_MAX) begin
                byte_index_next = 8'(byte_index_reg + 8'd1);
            end
        end
    end

    `AA55_ASSERT_NOW(a_start_at_zero, aclk, aresetn, res.frame_start, res.in_frame && res.position == 8'd0)
    `AA55_ASSERT_NOW(a_good_at_end, aclk, aresetn, res.frame_good, res.frame_end && res.error_kind == aa55_pkg::ERR_NONE)
    `AA55_ASSERT_NEXT(a_end_then_hunt, aclk, aresetn, in_fire && res.frame_end, phase_reg == aa55_pkg::PH_HUNT)
    `AA55_ASSERT_NOW(a_idle_pos_zero, aclk, aresetn, !res.in_frame, res.position == 8'd0)

endmodule

[rtl/core/aa55_skid.sv]
`include "aa55_frame_deframer_macros.svh"

module aa55_skid (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  aa55_pkg::beat_t in_beat,
    output logic            out_valid,
    input  logic            out_ready,
    output aa55_pkg::beat_t out_beat
);

    logic            main_valid_reg;
    logic            skid_valid_reg;
    aa55_pkg::beat_t main_reg;
    aa55_pkg::beat_t skid_reg;
    logic            in_fire;
    logic            main_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            main_valid_reg <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : in_beat;
        end else if (in_fire) begin
            skid_reg <= in_beat;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_beat  = main_reg;

    `AA55_ASSERT_NOW(a_skid_needs_main, aclk, aresetn, skid_valid_reg, main_valid_reg)
    `AA55_ASSERT_NEXT(a_stall_holds, aclk, aresetn, main_valid_reg && !out_ready, main_valid_reg)
    `AA55_ASSERT_NEXT(a_skid_fill, aclk, aresetn, in_fire && main_valid_reg && !out_ready, skid_valid_reg)

endmodule
